FILE: hdl/tmis_pkg.sv
// Shared types and constants for the tape-machine instruction step block.
// Depends on nothing; every other file in hdl/ imports it.
`default_nettype none

package tmis_pkg;

    localparam int CELL_COUNT = 16384;
    localparam int PROG_DEPTH = 65536;
    localparam int PTR_W      = $clog2(CELL_COUNT);
    localparam int CELL_W     = 32;
    localparam int ADDR_W     = 16;
    localparam int NEXT_W     = 17;
    localparam int POS_W      = 14;
    localparam int CHAR_W     = 8;
    localparam int QDEPTH     = 3;
    localparam int QIDX_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_STAR = 8'h2A;

    typedef enum logic [3:0] {
        MODE_INC   = 4'd0,
        MODE_DEC   = 4'd1,
        MODE_LEFT  = 4'd2,
        MODE_RIGHT = 4'd3,
        MODE_OPEN  = 4'd4,
        MODE_CLOSE = 4'd5,
        MODE_OUT   = 4'd6,
        MODE_IN    = 4'd7,
        MODE_NOP   = 4'd8
    } mode_t;

    // Input request as packed on s_axis_tdata (last field lowest)
    typedef struct packed {
        logic signed [7:0]  in_byte;
        logic [ADDR_W-1:0]  match_addr;
        logic [ADDR_W-1:0]  prog_addr;
        logic [3:0]         mode;
    } in_item_t;

    // Request handed to the execute stage, with the cell pointer after the step
    typedef struct packed {
        in_item_t           item;
        logic [PTR_W-1:0]   ptr;
    } exec_req_t;

    // Result as packed on m_axis_tdata (last field lowest)
    typedef struct packed {
        logic [POS_W-1:0]          tape_pos;
        logic signed [CELL_W-1:0]  cell_now;
        logic [CHAR_W-1:0]         out_char;
        logic                      char_valid;
        logic [NEXT_W-1:0]         next_addr;
    } result_t;

    typedef struct packed {
        logic               en;
        logic [PTR_W-1:0]   addr;
        logic [CELL_W-1:0]  data;
    } tape_wr_t;

endpackage

`default_nettype wire

FILE: hdl/tape_machine_instruction_step_top.sv
// Top level of the tape-machine instruction step block: pointer, reset clearing
// sweep, handshakes. Depends on tmis_pkg, tmis_tape_mem, tmis_exec, tmis_out_queue.
`default_nettype none

// One request on s_axis carries one tape-machine command; one result leaves on
// m_axis for every request, in order. The block sustains one request per clock
// while the result queue has room: the cell pointer is updated at acceptance,
// the tape cell is read from a synchronous memory, and the next cycle modifies
// it, writes it back and queues the result, which is offered on m_axis from
// the head of the queue. Back-to-back commands on the same cell see each
// other's writes through a forwarding path around the memory. The tape (16384
// cells of 32 bits) is cleared after reset by a sweep of one cell per clock:
// s_axis_tready stays low until every cell has been cleared. A three-deep
// result queue lets the input keep flowing while a finished result waits on
// m_axis_tready; after the sweep, input stalls only when the queued results
// plus the one in the execute stage reach the queue depth.
module tape_machine_instruction_step_top
    import tmis_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [3:0] mode, [19:4] prog_addr, [35:20] match_addr, [43:36] in_byte, [47:44] unused
    input  wire logic [47:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [16:0] next_addr, [17] char_valid, [25:18] out_char, [57:26] cell_now,
    // [71:58] tape_pos
    output logic [71:0]       m_axis_tdata
);

    logic              clearing_reg;
    logic [PTR_W-1:0]  clr_addr_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_next;
    logic              in_acc;
    logic              out_acc;
    in_item_t          item;
    exec_req_t         req;
    logic [CELL_W-1:0] rd_data;
    logic              res_valid;
    result_t           res;
    tape_wr_t          exec_wr;
    tape_wr_t          mem_wr;
    result_t           head;
    logic [QCNT_W-1:0] q_count;
    logic [QCNT_W:0]   in_flight;

    assign item    = in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Hold off requests while the tape is being cleared or the queue could fill
    assign in_flight     = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(res_valid);
    assign s_axis_tready = !clearing_reg && (in_flight < (QCNT_W+1)'(QDEPTH));

    // Advance the pointer at acceptance; wrap at both ends of the tape
    always_comb
    begin
        ptr_next = ptr_reg;
        if (in_acc)
        begin
            unique case (item.mode)
                MODE_LEFT:
                begin
                    ptr_next = (ptr_reg == '0) ? PTR_W'(CELL_COUNT - 1)
                                               : ptr_reg - PTR_W'(1);
                end
                MODE_RIGHT:
                begin
                    ptr_next = (ptr_reg == PTR_W'(CELL_COUNT - 1)) ? '0
                                                                   : ptr_reg + PTR_W'(1);
                end
                default:
                begin
                    ptr_next = ptr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            ptr_reg      <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + PTR_W'(1);
                if (clr_addr_reg == PTR_W'(CELL_COUNT - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    assign req.item = item;
    assign req.ptr  = ptr_next;

    // Clearing sweep owns the write port until it finishes
    always_comb
    begin
        if (clearing_reg)
        begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = clr_addr_reg;
            mem_wr.data = '0;
        end
        else
        begin
            mem_wr = exec_wr;
        end
    end

    tmis_tape_mem u_tape (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (in_acc),
        .rd_addr (ptr_next),
        .rd_data (rd_data)
    );

    tmis_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (in_acc),
        .req       (req),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res       (res),
        .wr        (exec_wr)
    );

    tmis_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (out_acc),
        .not_empty (m_axis_tvalid),
        .head      (head),
        .count     (q_count)
    );

    assign m_axis_tdata = head;

    a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s_axis_tready)
        else $error("request taken during tape clearing");

    a_ptr_moves_on_request: assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc |=> $stable(ptr_reg))
        else $error("cell pointer moved without a request");

    a_request_executes: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> res_valid)
        else $error("accepted request did not reach the execute stage");

endmodule

`default_nettype wire

FILE: hdl/tmis_tape_mem.sv
// Tape storage: single write port, one registered read port (old data on collision).
// Depends on tmis_pkg.
`default_nettype none

module tmis_tape_mem
    import tmis_pkg::*;
(
    input  wire logic              clk,
    input  wire tape_wr_t          wr,
    input  wire logic              rd_en,
    input  wire logic [PTR_W-1:0]  rd_addr,
    output logic [CELL_W-1:0]      rd_data
);

    logic [CELL_W-1:0] mem [CELL_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tmis_exec.sv
// Execute stage: takes the cell read back from the tape, forwards the last write,
// applies the command, writes the cell back and forms the result. Depends on tmis_pkg.
`default_nettype none

module tmis_exec
    import tmis_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              acc,
    input  wire exec_req_t         req,
    input  wire logic [CELL_W-1:0] rd_data,
    output logic                   res_valid,
    output result_t                res,
    output tape_wr_t               wr
);

    logic       valid_reg;
    exec_req_t  req_reg;
    tape_wr_t   last_wr_reg;

    logic [CELL_W-1:0] cur;
    logic [CELL_W-1:0] upd;
    logic              do_wr;
    logic [NEXT_W-1:0] next_v;
    logic [CHAR_W-1:0] byte_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= 1'b0;
            last_wr_reg.en   <= 1'b0;
            last_wr_reg.addr <= '0;
            last_wr_reg.data <= '0;
        end
        else
        begin
            valid_reg        <= acc;
            last_wr_reg.en   <= wr.en;
            last_wr_reg.addr <= wr.addr;
            last_wr_reg.data <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            req_reg <= req;
        end
    end

    // The write of the previous cycle is not yet visible in the read data
    assign cur = (last_wr_reg.en && last_wr_reg.addr == req_reg.ptr)
                 ? last_wr_reg.data : rd_data;

    assign byte_v = cur[CHAR_W-1:0];

    always_comb
    begin
        upd    = cur;
        do_wr  = 1'b0;
        next_v = NEXT_W'(req_reg.item.prog_addr) + NEXT_W'(1);
        res.char_valid = 1'b0;
        res.out_char   = '0;
        unique case (req_reg.item.mode)
            MODE_INC:
            begin
                upd   = cur + CELL_W'(1);
                do_wr = 1'b1;
            end
            MODE_DEC:
            begin
                upd   = cur - CELL_W'(1);
                do_wr = 1'b1;
            end
            MODE_OPEN:
            begin
                if (cur == '0)
                begin
                    next_v = NEXT_W'(req_reg.item.match_addr) + NEXT_W'(1);
                end
            end
            MODE_CLOSE:
            begin
                next_v = NEXT_W'(req_reg.item.match_addr);
            end
            MODE_OUT:
            begin
                res.char_valid = 1'b1;
                res.out_char   = byte_v[CHAR_W-1] ? CHAR_STAR : byte_v;
            end
            MODE_IN:
            begin
                upd   = CELL_W'(req_reg.item.in_byte);
                do_wr = 1'b1;
            end
            default:
            begin
                upd = cur;
            end
        endcase
        // Saturate at the end of the program
        if (next_v > NEXT_W'(PROG_DEPTH))
        begin
            next_v = NEXT_W'(PROG_DEPTH);
        end
        res.next_addr = next_v;
        res.cell_now  = upd;
        res.tape_pos  = POS_W'(req_reg.ptr);
    end

    assign wr.en     = valid_reg && do_wr;
    assign wr.addr   = req_reg.ptr;
    assign wr.data   = upd;
    assign res_valid = valid_reg;

endmodule

`default_nettype wire

FILE: hdl/tmis_out_queue.sv
// Small result queue that decouples the execute stage from the output handshake.
// Depends on tmis_pkg.
`default_nettype none

module tmis_out_queue
    import tmis_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire result_t       push_data,
    input  wire logic          pop,
    output logic               not_empty,
    output result_t            head,
    output logic [QCNT_W-1:0]  count
);

    result_t              q [QDEPTH];
    logic [QIDX_W-1:0]    wr_idx_reg;
    logic [QIDX_W-1:0]    rd_idx_reg;
    logic [QCNT_W-1:0]    count_reg;
    logic [QCNT_W-1:0]    count_next;

    function automatic logic [QIDX_W-1:0] bump(input logic [QIDX_W-1:0] idx);
        return (idx == QIDX_W'(QDEPTH - 1)) ? '0 : idx + QIDX_W'(1);
    endfunction

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_idx_reg <= bump(wr_idx_reg);
            end
            if (pop)
            begin
                rd_idx_reg <= bump(rd_idx_reg);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q[wr_idx_reg] <= push_data;
        end
    end

    assign head      = q[rd_idx_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QCNT_W'(QDEPTH)) |-> (!push || pop))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("result queue popped while empty");

endmodule

`default_nettype wire
